// ===== sv/dphf_pkg.sv =====
package dphf_pkg;

	localparam int SRC_W      = 8;
	localparam int SEQ_W      = 8;
	localparam int PAIR_W     = SRC_W + SEQ_W;
	localparam int TIMER_W    = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_CLEAR_TIMEOUT = '0;

	localparam logic [TIMER_W-1:0] CLEAR_TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

// ===== sv/dphf_if.sv =====
interface dphf_in_if import dphf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [SRC_W-1:0] source_addr;
	logic [SEQ_W-1:0] sequence_num;

	modport source (output valid, kind, source_addr, sequence_num, input ready);
	modport sink (input valid, kind, source_addr, sequence_num, output ready);
endinterface

interface dphf_out_if;
	logic valid;
	logic ready;
	logic is_new;

	modport source (output valid, is_new, input ready);
	modport sink (input valid, is_new, output ready);
endinterface

// ===== sv/dphf_ram.sv =====
module dphf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/duplicate_packet_history_filter.sv =====
// Keeps the last HISTORY_DEPTH (source, sequence) pairs in a RAM and reports for each
// packet transaction whether its pair is new. A packet's result waits for a walk over
// the whole history through the single RAM read port and then the write state; a tick
// skips the walk and goes straight to the done state. The next transaction can be
// accepted from the cycle in which the result is presented.
// History order is kept by a rotating base pointer,
// and per-entry valid bits let a timeout clear the whole history at once, so no
// clearing pass follows reset.
module duplicate_packet_history_filter import dphf_pkg::*; #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dphf_in_if.sink               item,
	dphf_out_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(HISTORY_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

	function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base, logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_EXT) begin
			sum = sum - DEPTH_EXT;
		end
		return sum[IDX_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         base_q;
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [TIMER_W-1:0]       timer_q;
	logic [TIMER_W-1:0]       clear_timeout_q;
	logic [PAIR_W-1:0]        pair_q;
	logic                     seen_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_addr_q;
	logic                     is_new_q;
	logic                     res_new_q;
	logic                     out_valid_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic [IDX_W-1:0]         rd_addr_s1;

	logic                     item_fire;
	logic                     rd_issue;
	logic [IDX_W-1:0]         rd_addr;
	logic [PAIR_W-1:0]        rd_data;
	logic [PAIR_W-1:0]        entry;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic                     out_load;
	logic                     scan_last;
	logic                     cfg_wr;
	logic [REG_IDX_W-1:0]     cfg_idx;

	dphf_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (pair_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		item.ready = (state_q == ST_IDLE);
		item_fire  = item.valid && item.ready;
		rd_issue   = (state_q == ST_SCAN) && (cnt_q < DEPTH_CNT);
		rd_addr    = wrap_add(base_q, cnt_q[IDX_W-1:0]);
		entry      = valid_q[rd_addr_s1] ? rd_data : '0;
		scan_last  = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
		wr_en      = (state_q == ST_WRITE) && !seen_q;
		wr_addr    = free_found_q ? free_addr_q : base_q;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);
		result.valid  = out_valid_q;
		result.is_new = res_new_q;
		cfg_idx = paddr[APB_ADDR_W-1:2];
		cfg_wr  = psel && penable && pwrite;
		pready  = 1'b1;
		prdata  = (cfg_idx == REG_CLEAR_TIMEOUT) ?
			APB_DATA_W'(clear_timeout_q) : '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					state_d = (item.kind == KIND_TICK) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			base_q          <= '0;
			valid_q         <= '0;
			timer_q         <= '0;
			clear_timeout_q <= CLEAR_TIMEOUT_RESET;
			seen_q          <= 1'b0;
			free_found_q    <= 1'b0;
			free_addr_q     <= '0;
			is_new_q        <= 1'b0;
			res_new_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			rd_vld_s1       <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;

			if (cfg_wr && (cfg_idx == REG_CLEAR_TIMEOUT)) begin
				clear_timeout_q <= pwdata[TIMER_W-1:0];
			end

			if (item_fire) begin
				if (item.kind == KIND_TICK) begin
					is_new_q <= 1'b0;
					if (timer_q == TIMER_W'(1)) begin
						valid_q <= '0;
						timer_q <= '0;
					end else if (timer_q > TIMER_W'(1)) begin
						timer_q <= timer_q - TIMER_W'(1);
					end
				end else begin
					timer_q      <= clear_timeout_q;
					cnt_q        <= '0;
					seen_q       <= 1'b0;
					free_found_q <= 1'b0;
				end
			end

			if (rd_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (rd_vld_s1) begin
				if (entry == pair_q) begin
					seen_q <= 1'b1;
				end
				if (!free_found_q && (entry[PAIR_W-1:SEQ_W] == '0)) begin
					free_found_q <= 1'b1;
					free_addr_q  <= rd_addr_s1;
				end
			end

			if (state_q == ST_WRITE) begin
				is_new_q <= !seen_q;
			end

			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				if (!free_found_q) begin
					base_q <= wrap_add(base_q, ONE_IDX);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				res_new_q   <= is_new_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			pair_q <= {item.source_addr, item.sequence_num};
		end
		rd_idx_s1  <= cnt_q[IDX_W-1:0];
		rd_addr_s1 <= rd_addr;
	end

endmodule

// ===== sv/dphf_checker.sv =====
module dphf_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic result_is_new
);

	// A result transaction that is stalled keeps its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_is_new))
		else $error("Stalled result changed or dropped.");

	// Only one transaction is processed at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("Input accepted while busy.");

	// A new result appears only as the block returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("Result presented while still busy.");

	// No result is shown while reset is asserted.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("Result valid during reset.");

endmodule

bind duplicate_packet_history_filter dphf_checker u_dphf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_is_new (result.is_new)
);
